>>> rtl/core/dfa_lexer_step_defines.svh
// assertion helpers for the lexer, used by dls_ctrl
`ifndef DFA_LEXER_STEP_DEFINES_SVH
`define DFA_LEXER_STEP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DLS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DLS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/dls_pkg.sv
`timescale 1ns / 1ps

package dls_pkg;

    localparam int CHAR_W  = 8;
    localparam int ROW_W   = 6;
    localparam int TGT_W   = 7;
    localparam int TOK_W   = 9;
    localparam int TOKID_W = 8;
    localparam int LEN_W   = 10;

    localparam logic [LEN_W-1:0]  LEN_MAX  = 10'd1023;
    localparam logic [CHAR_W-1:0] CHAR_MAX = 8'd127;

    typedef enum logic [1:0] {
        CMD_CHAR      = 2'd0,
        CMD_EOS       = 2'd1,
        CMD_WR_TRANS  = 2'd2,
        CMD_WR_ACCEPT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_TOKEN = 2'd0,
        KIND_EOS   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [TOKID_W-1:0] token_id;
        logic [LEN_W-1:0]   lexeme_length;
        logic               last;
    } result_t;

    // up to two results per transaction, v1 only together with v0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    // raw table words read for one character
    typedef struct packed {
        logic [TGT_W-1:0] trans_raw;
        logic [TGT_W-1:0] row0_raw;
        logic [TOK_W-1:0] accept_raw;
    } lkup_t;

endpackage

>>> rtl/core/dls_tables.sv
`timescale 1ns / 1ps

module dls_tables
    import dls_pkg::*;
#(
    parameter int NUM_STATES = 64,
    parameter int SW         = 6,
    parameter int CW         = 7
)
(
    input  logic             clk,
    input  logic             we_trans,
    input  logic             we_accept,
    input  logic [SW-1:0]    wr_row,
    input  logic [CW-1:0]    wr_col,
    input  logic [TGT_W-1:0] wr_trans_data,
    input  logic [TOK_W-1:0] wr_accept_data,
    input  logic             rd_en,
    input  logic [SW-1:0]    rd_state,
    input  logic [CW-1:0]    rd_ch,
    output lkup_t            rd_data
);

    localparam int TRANS_DEPTH = NUM_STATES * (2 ** CW);
    localparam logic [SW-1:0] START_ROW = '0;

    logic [TGT_W-1:0] trans_mem  [TRANS_DEPTH];
    logic [TOK_W-1:0] accept_mem [NUM_STATES];

    logic [TGT_W-1:0] trans_rd_reg;
    logic [TGT_W-1:0] row0_rd_reg;     // second read port, row 0 for the restart lookup
    logic [TOK_W-1:0] accept_rd_reg;

    always_ff @(posedge clk)
    begin
        if (we_trans)
        begin
            trans_mem[{wr_row, wr_col}] <= wr_trans_data;
        end
        if (rd_en)
        begin
            trans_rd_reg <= trans_mem[{rd_state, rd_ch}];
            row0_rd_reg  <= trans_mem[{START_ROW, rd_ch}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_accept)
        begin
            accept_mem[wr_row] <= wr_accept_data;
        end
        if (rd_en)
        begin
            accept_rd_reg <= accept_mem[rd_state];
        end
    end

    assign rd_data = {trans_rd_reg, row0_rd_reg, accept_rd_reg};

endmodule

>>> rtl/core/dls_ctrl.sv
`timescale 1ns / 1ps
`include "dfa_lexer_step_defines.svh"

module dls_ctrl
    import dls_pkg::*;
#(
    parameter int NUM_STATES = 64,
    parameter int NUM_TOKENS = 256,
    parameter int SW         = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cmd_t              cmd,
    input  logic [CHAR_W-1:0] char_code,
    input  lkup_t             lkup,
    output logic [SW-1:0]     state,
    output logic              busy,
    output push_t             push
);

    logic              s1_valid_reg, s1_valid_next;
    logic [SW-1:0]     state_reg, state_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    cmd_t              cmd_reg;
    logic [CHAR_W-1:0] char_reg;

    logic    is_eos, pending, trans_ok, row0_ok, accept_ok;
    result_t rep, end_res, err_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= '0;
            count_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            state_reg    <= state_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg  <= cmd;
            char_reg <= char_code;
        end
    end

    always_comb
    begin
        is_eos    = (cmd_reg != CMD_CHAR) || (char_reg == '0) || (char_reg > CHAR_MAX);
        pending   = (count_reg != '0);
        trans_ok  = !lkup.trans_raw[TGT_W-1] && (int'(lkup.trans_raw[TGT_W-2:0]) < NUM_STATES);
        row0_ok   = !lkup.row0_raw[TGT_W-1] && (int'(lkup.row0_raw[TGT_W-2:0]) < NUM_STATES);
        accept_ok = !lkup.accept_raw[TOK_W-1]
                    && (int'(lkup.accept_raw[TOK_W-2:0]) < NUM_TOKENS);

        rep.kind          = accept_ok ? KIND_TOKEN : KIND_ERROR;
        rep.token_id      = accept_ok ? lkup.accept_raw[TOKID_W-1:0] : '0;
        rep.lexeme_length = count_reg;
        rep.last          = 1'b0;

        end_res.kind          = KIND_EOS;
        end_res.token_id      = '0;
        end_res.lexeme_length = '0;
        end_res.last          = 1'b1;

        err_res.kind          = KIND_ERROR;
        err_res.token_id      = '0;
        err_res.lexeme_length = LEN_W'(1);
        err_res.last          = 1'b1;

        s1_valid_next = start;
        state_next    = state_reg;
        count_next    = count_reg;
        push          = '0;

        if (s1_valid_reg)
        begin
            priority if (is_eos)
            begin
                // flush any pending lexeme, then the end marker
                push.v0    = 1'b1;
                push.r0    = pending ? rep : end_res;
                push.v1    = pending;
                push.r1    = end_res;
                state_next = '0;
                count_next = '0;
            end
            else if (pending && trans_ok)
            begin
                state_next = SW'(lkup.trans_raw[TGT_W-2:0]);
                count_next = (count_reg == LEN_MAX) ? count_reg : count_reg + LEN_W'(1);
            end
            else if (pending)
            begin
                // lexeme ends, restart from state 0 with this character
                push.v0 = 1'b1;
                push.r0 = rep;
                if (row0_ok)
                begin
                    push.r0.last = 1'b1;
                    state_next   = SW'(lkup.row0_raw[TGT_W-2:0]);
                    count_next   = LEN_W'(1);
                end
                else
                begin
                    push.v1    = 1'b1;
                    push.r1    = err_res;
                    state_next = '0;
                    count_next = '0;
                end
            end
            else if (trans_ok)
            begin
                state_next = SW'(lkup.trans_raw[TGT_W-2:0]);
                count_next = LEN_W'(1);
            end
            else
            begin
                // no move from the start state: drop the character
                push.v0    = 1'b1;
                push.r0    = err_res;
                state_next = '0;
                count_next = '0;
            end
        end
    end

    assign state = state_reg;
    assign busy  = s1_valid_reg;

    `DLS_ASSERT_IMP(a_idle_at_start, count_reg == '0, state_reg == '0, "state set without lexeme")
    `DLS_ASSERT_NXT(a_one_in_flight, s1_valid_reg, !s1_valid_reg, "two items in lookup stage")
    `DLS_ASSERT_IMP(a_pair_last, push.v1, push.r1.last && !push.r0.last && push.v0, "bad result pair")
    `DLS_ASSERT_IMP(a_single_last, push.v0 && !push.v1, push.r0.last, "single result not last")

endmodule

>>> rtl/core/dls_out_fifo.sv
`timescale 1ns / 1ps

module dls_out_fifo
    import dls_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  logic    pop,
    output logic    out_valid,
    output result_t out_data,
    output logic    room
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    result_t          fifo_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic             do_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            fifo_mem[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            fifo_mem[wr_ptr_plus1] <= push.r1;
        end
    end

    always_comb
    begin
        wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
        do_pop       = pop && (count_reg != '0);
        wr_ptr_next  = wr_ptr_reg + PTR_W'(push.v0) + PTR_W'(push.v1);
        rd_ptr_next  = rd_ptr_reg + PTR_W'(do_pop);
        count_next   = count_reg + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(do_pop);
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = fifo_mem[rd_ptr_reg];
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));

endmodule

>>> rtl/core/dfa_lexer_step.sv
`timescale 1ns / 1ps

// dfa_lexer_step: table-driven DFA tokenizer on a stream interface. Load the
// transition table (command 2, one entry per transaction) and the accept
// table (command 3) before sending characters; both tables come up undefined
// and there is no clearing pass, so every entry the lexer can reach must be
// written first. Character transactions (command 0) step the DFA; end of
// stream (command 1, or any character outside 1..127) flushes the pending
// lexeme and emits an end marker. A transaction yields zero, one or two
// results, the final one flagged with tlast. Table writes go in one per
// cycle while no lookup is in flight and the output queue has room; a
// character or end-of-stream transaction waits until the state loop through
// the transition memory (synchronous read, then state update) is done for
// the one before. Results pass through a four-entry output queue, so input
// keeps flowing while the master side stalls, until the queue is nearly full.
module dfa_lexer_step
    import dls_pkg::*;
#(
    parameter int NUM_STATES    = 64,
    parameter int NUM_TOKENS    = 256,
    parameter int ALPHABET_SIZE = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_code[7:0], state_index[13:8], next_state_value[20:14],
    // token_value[29:21], zero fill [31:30]
    input  logic [31:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  s_axis_tuser,
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // token_id[7:0], lexeme_length[17:8], zero fill [23:18]
    output logic [23:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int SW = $clog2(NUM_STATES);
    localparam int CW = $clog2(ALPHABET_SIZE);

    // input field unpacking
    cmd_t              in_cmd;
    logic [CHAR_W-1:0] in_char;
    logic [ROW_W-1:0]  in_row;
    logic [TGT_W-1:0]  in_target;
    logic [TOK_W-1:0]  in_token;

    logic    in_fire;
    logic    row_ok, col_ok;
    logic    we_trans, we_accept, lookup_start;
    logic    busy, room;
    logic [SW-1:0] cur_state;
    lkup_t   lkup;
    push_t   push;
    result_t out_res;

    assign in_cmd    = cmd_t'(s_axis_tuser);
    assign in_char   = s_axis_tdata[7:0];
    assign in_row    = s_axis_tdata[13:8];
    assign in_target = s_axis_tdata[20:14];
    assign in_token  = s_axis_tdata[29:21];

    // one lookup in flight at a time, and space for two results
    assign s_axis_tready = !busy && room;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // writes outside the table bounds are dropped
    assign row_ok = (int'(in_row) < NUM_STATES);
    assign col_ok = (int'(in_char) < ALPHABET_SIZE);

    assign we_trans     = in_fire && (in_cmd == CMD_WR_TRANS) && row_ok && col_ok;
    assign we_accept    = in_fire && (in_cmd == CMD_WR_ACCEPT) && row_ok;
    assign lookup_start = in_fire && ((in_cmd == CMD_CHAR) || (in_cmd == CMD_EOS));

    dls_tables #(
        .NUM_STATES (NUM_STATES),
        .SW         (SW),
        .CW         (CW)
    ) u_tables (
        .clk            (clk),
        .we_trans       (we_trans),
        .we_accept      (we_accept),
        .wr_row         (SW'(in_row)),
        .wr_col         (in_char[CW-1:0]),
        .wr_trans_data  (in_target),
        .wr_accept_data (in_token),
        .rd_en          (lookup_start),
        .rd_state       (cur_state),
        .rd_ch          (in_char[CW-1:0]),
        .rd_data        (lkup)
    );

    // state update and result generation, in the cycle after the read
    dls_ctrl #(
        .NUM_STATES (NUM_STATES),
        .NUM_TOKENS (NUM_TOKENS),
        .SW         (SW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (lookup_start),
        .cmd       (in_cmd),
        .char_code (in_char),
        .lkup      (lkup),
        .state     (cur_state),
        .busy      (busy),
        .push      (push)
    );

    // decouples result delivery from the lookup loop
    dls_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_res),
        .room      (room)
    );

    assign m_axis_tdata = {6'b0, out_res.lexeme_length, out_res.token_id};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

>>> verif/tb_dfa_lexer_step.sv
`timescale 1ns / 1ps

module tb_dfa_lexer_step;
    import dls_pkg::*;

    localparam int NUM_ST  = 64;
    localparam int NUM_TOK = 256;
    localparam int ALPHA   = 128;

    // table words meaning "no transition" and "not accepting"
    localparam logic [TGT_W-1:0] NO_MOVE       = 7'h7F;
    localparam logic [TOK_W-1:0] NOT_ACCEPTING = 9'h1FF;

    localparam logic [CHAR_W-1:0] CH_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_B = 8'h62;

    // the long receiver hold starts once this many transactions went in
    localparam int PRESSURE_AT = 1600;
    localparam int PRESSURE_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // receiver held off by the pressure process
    logic rx_hold = 1'b0;
    int   sent_items = 0;

    // states and characters the current table set can reach
    logic [ROW_W-1:0]  live_states[$];
    logic [CHAR_W-1:0] live_chars[$];

    dfa_lexer_step #(
        .NUM_STATES    (NUM_ST),
        .NUM_TOKENS    (NUM_TOK),
        .ALPHABET_SIZE (ALPHA)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // lexer predictor plus the queue of results still owed by the block
    class lexer_scoreboard;
        logic [TGT_W-1:0] trans_mem [NUM_ST*ALPHA];
        logic [TOK_W-1:0] accept_mem [NUM_ST];
        logic [ROW_W-1:0] cur_state;
        logic [LEN_W-1:0] run_len;
        result_t          lex_results_due[$];
        int mismatches, checked;
        int n_writes, n_chars, n_ends;
        int n_tokens, n_errors, n_markers, n_saturated;

        function new();
            cur_state = '0;
            run_len = '0;
            mismatches = 0;
            checked = 0;
            n_writes = 0;
            n_chars = 0;
            n_ends = 0;
            n_tokens = 0;
            n_errors = 0;
            n_markers = 0;
            n_saturated = 0;
        endfunction

        // next state for a character, -1 when there is no move
        function int next_state_of(logic [ROW_W-1:0] st, logic [CHAR_W-1:0] ch);
            logic signed [TGT_W-1:0] v;
            if (ch >= ALPHA)
                return -1;
            v = trans_mem[st*ALPHA + ch];
            if (v < 0 || v >= NUM_ST)
                return -1;
            return v;
        endfunction

        function result_t make_result(kind_t k, logic [TOKID_W-1:0] tok,
                                      logic [LEN_W-1:0] len);
            result_t r;
            r.kind = k;
            r.token_id = tok;
            r.lexeme_length = len;
            r.last = 1'b0;
            return r;
        endfunction

        // the pending lexeme, reported at the current state
        function result_t lexeme_result();
            logic signed [TOK_W-1:0] t;
            t = accept_mem[cur_state];
            if (t < 0 || t >= NUM_TOK)
                return make_result(KIND_ERROR, '0, run_len);
            return make_result(KIND_TOKEN, t[TOKID_W-1:0], run_len);
        endfunction

        function void tokenize_item(cmd_t cmd, logic [CHAR_W-1:0] ch,
                                    logic [ROW_W-1:0] row, logic [TGT_W-1:0] tgt,
                                    logic [TOK_W-1:0] tok);
            result_t batch[$];
            int nx;
            if (cmd == CMD_WR_TRANS) begin
                n_writes++;
                if (row < NUM_ST && ch < ALPHA)
                    trans_mem[row*ALPHA + ch] = tgt;
                return;
            end
            if (cmd == CMD_WR_ACCEPT) begin
                n_writes++;
                if (row < NUM_ST)
                    accept_mem[row] = tok;
                return;
            end
            if (cmd == CMD_EOS || ch < 1 || ch > CHAR_MAX) begin
                // end of stream: flush the lexeme, then the end marker
                n_ends++;
                if (run_len != 0)
                    batch = {batch, lexeme_result()};
                batch = {batch, make_result(KIND_EOS, '0, '0)};
                cur_state = '0;
                run_len = '0;
            end else begin
                n_chars++;
                nx = next_state_of(cur_state, ch);
                if (nx >= 0 && run_len != 0) begin
                    cur_state = nx[ROW_W-1:0];
                    if (run_len < LEN_MAX)
                        run_len++;
                    return;
                end
                if (run_len != 0) begin
                    if (run_len == LEN_MAX)
                        n_saturated++;
                    batch = {batch, lexeme_result()};
                    cur_state = '0;
                    run_len = '0;
                    nx = next_state_of('0, ch);
                end
                if (nx >= 0) begin
                    cur_state = nx[ROW_W-1:0];
                    run_len = LEN_W'(1);
                end else begin
                    // no move even from the start state: character is dropped
                    batch = {batch, make_result(KIND_ERROR, '0, LEN_W'(1))};
                    cur_state = '0;
                    run_len = '0;
                end
            end
            if (batch.size() != 0)
                batch[batch.size()-1].last = 1'b1;
            lex_results_due = {lex_results_due, batch};
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (lex_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d tok %0d len %0d last %0d",
                             got.kind, got.token_id, got.lexeme_length, got.last);
                return;
            end
            want = lex_results_due.pop_front();
            checked++;
            case (want.kind)
                KIND_TOKEN: n_tokens++;
                KIND_ERROR: n_errors++;
                default:    n_markers++;
            endcase
            if (got.kind !== want.kind || got.token_id !== want.token_id ||
                got.lexeme_length !== want.lexeme_length || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: got kind %0d tok %0d len %0d last %0d, %s",
                             checked, got.kind, got.token_id, got.lexeme_length,
                             got.last, $sformatf("expected kind %0d tok %0d len %0d last %0d",
                             want.kind, want.token_id, want.lexeme_length, want.last));
            end
        endfunction
    endclass

    lexer_scoreboard lex_sb;

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one transaction on the slave side; idle gap drawn per transaction,
    // with stretches of back-to-back traffic
    task automatic send_item(cmd_t cmd, logic [CHAR_W-1:0] ch, logic [ROW_W-1:0] row,
                             logic [TGT_W-1:0] tgt, logic [TOK_W-1:0] tok);
        int gap;
        gap = ((sent_items / 150) % 4 == 3) ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, tok, tgt, row, ch};
        s_axis_tuser  <= cmd;
        do @(posedge clk); while (!s_axis_tready);
        lex_sb.tokenize_item(cmd, ch, row, tgt, tok);
        sent_items++;
    endtask

    // unused fields carry random junk the block must ignore
    task automatic send_char(logic [CHAR_W-1:0] ch);
        send_item(CMD_CHAR, ch, ROW_W'($urandom), TGT_W'($urandom), TOK_W'($urandom));
    endtask

    task automatic send_end();
        send_item(CMD_EOS, CHAR_W'($urandom), ROW_W'($urandom), TGT_W'($urandom),
                  TOK_W'($urandom));
    endtask

    task automatic wr_trans(logic [ROW_W-1:0] row, logic [CHAR_W-1:0] col,
                            logic [TGT_W-1:0] tgt);
        send_item(CMD_WR_TRANS, col, row, tgt, TOK_W'($urandom));
    endtask

    task automatic wr_accept(logic [ROW_W-1:0] row, logic [TOK_W-1:0] tok);
        send_item(CMD_WR_ACCEPT, CHAR_W'($urandom), row, TGT_W'($urandom), tok);
    endtask

    // transitions only ever point into the live state set
    function automatic logic [TGT_W-1:0] pick_target();
        if ($urandom_range(0, 9) < 3)
            return NO_MOVE;
        return TGT_W'(live_states[$urandom_range(0, live_states.size() - 1)]);
    endfunction

    function automatic logic [TOK_W-1:0] pick_token();
        if ($urandom_range(0, 3) == 0)
            return NOT_ACCEPTING;
        return TOK_W'($urandom_range(0, 255));
    endfunction

    // fresh random DFA: every table word a live character can reach gets written,
    // column 0 included so a zero character's end-of-stream lookup sees a written word
    task automatic load_tables();
        int ns;
        int nc;
        ns = $urandom_range(2, 8);
        nc = $urandom_range(2, 12);
        live_states.delete();
        live_chars.delete();
        live_states = {live_states, ROW_W'(0)};
        repeat (ns - 1)
            live_states = {live_states, ROW_W'($urandom_range(1, NUM_ST - 1))};
        repeat (nc)
            live_chars = {live_chars, CHAR_W'($urandom_range(1, CHAR_MAX))};
        foreach (live_states[i])
        begin
            wr_accept(live_states[i], pick_token());
            wr_trans(live_states[i], 8'd0, TGT_W'($urandom));
            foreach (live_chars[j])
                wr_trans(live_states[i], live_chars[j], pick_target());
        end
    endtask

    // mostly characters of the live alphabet, with table rewrites, ends of
    // stream, out-of-range characters and writes the block has to drop
    task automatic run_stream(int n);
        int roll;
        repeat (n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 78)
                send_char(live_chars[$urandom_range(0, live_chars.size() - 1)]);
            else if (roll < 83)
                send_end();
            else if (roll < 86)
                send_char(($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(128, 255)));
            else if (roll < 93)
                wr_trans(live_states[$urandom_range(0, live_states.size() - 1)],
                         live_chars[$urandom_range(0, live_chars.size() - 1)], pick_target());
            else if (roll < 97)
                wr_accept(live_states[$urandom_range(0, live_states.size() - 1)],
                          pick_token());
            else
                wr_trans(ROW_W'($urandom), 8'($urandom_range(128, 255)), TGT_W'($urandom));
        end
    endtask

    // receiver: after each result transaction it may hold tready low for a random
    // gap, with calm stretches where it never stalls, and it obeys the long hold
    initial
    begin
        int hold;
        result_t got;
        hold = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind          = kind_t'(m_axis_tuser);
                got.token_id      = m_axis_tdata[7:0];
                got.lexeme_length = m_axis_tdata[17:8];
                got.last          = m_axis_tlast;
                lex_sb.check_result(got);
                hold = ((lex_sb.checked / 120) % 4 == 1) ? 0 : $urandom_range(0, 6);
            end
            if (rx_hold || hold > 0)
            begin
                m_axis_tready <= 1'b0;
                if (hold > 0)
                    hold--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // long receiver stall while the sender keeps offering transactions, so
    // the output queue fills and the slave side backs up
    initial
    begin
        wait (sent_items >= PRESSURE_AT);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", lex_sb.lex_results_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int rand_start;
        lex_sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_CHAR;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed DFA over states 0, 1, 2, 63 and characters 1, a, b, 127
        live_states = '{6'd0, 6'd1, 6'd2, 6'd63};
        live_chars = '{8'd1, CH_A, CH_B, CHAR_MAX};
        wr_accept(6'd0, NOT_ACCEPTING);
        wr_accept(6'd1, 9'd0);
        wr_accept(6'd2, 9'd255);
        wr_accept(6'd63, NOT_ACCEPTING);
        foreach (live_states[i])
        begin
            wr_trans(live_states[i], 8'd0, NO_MOVE);
            foreach (live_chars[j])
                wr_trans(live_states[i], live_chars[j], NO_MOVE);
        end
        wr_trans(6'd0, 8'd1, 7'd63);
        wr_trans(6'd0, CH_A, 7'd1);
        wr_trans(6'd0, CH_B, 7'd2);
        wr_trans(6'd1, CH_A, 7'd1);
        wr_trans(6'd2, CH_B, 7'd2);
        wr_trans(6'd63, CH_A, 7'd0);
        wr_trans(6'd63, CHAR_MAX, 7'd63);
        // columns past the alphabet must be dropped
        wr_trans(6'd63, 8'd255, 7'd0);
        wr_trans(6'd0, 8'd128, NO_MOVE);

        // token on no move, restart from state 0 with the same character
        send_char(CH_A);
        send_char(CH_A);
        send_char(CH_B);
        // token then a dropped character: two results in one transaction
        send_char(CHAR_MAX);
        // non-accepting lexeme reported as an error
        send_char(8'd1);
        send_char(CHAR_MAX);
        send_char(CH_B);
        // end of stream with and without a pending lexeme
        send_end();
        send_end();
        // characters outside 1..127 act as end of stream
        send_char(8'd0);
        send_char(CH_A);
        send_char(8'd255);
        send_char(CH_A);
        send_char(8'd128);
        // no move from the start state with nothing pending
        send_char(CHAR_MAX);
        // a lexeme passing back through state 0
        send_char(8'd1);
        send_char(CH_A);
        send_char(CH_A);
        send_end();

        // lexeme long enough to saturate the length counter
        repeat (1031) send_char(CH_A);
        send_char(CH_B);
        send_end();

        // random DFAs with random text
        rand_start = sent_items;
        while (sent_items - rand_start < 700)
        begin
            load_tables();
            run_stream($urandom_range(120, 260));
            send_end();
        end

        s_axis_tvalid <= 1'b0;
        while (lex_sb.lex_results_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d table writes, %0d characters, %0d stream ends",
                 lex_sb.n_writes, lex_sb.n_chars, lex_sb.n_ends);
        $display("checked %0d results: %0d tokens, %0d errors, %0d end markers, %0d saturated",
                 lex_sb.checked, lex_sb.n_tokens, lex_sb.n_errors, lex_sb.n_markers,
                 lex_sb.n_saturated);
        if (lex_sb.mismatches == 0 && lex_sb.lex_results_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> dfa_lexer_step.f
+incdir+rtl/core
rtl/core/dls_pkg.sv
rtl/core/dls_tables.sv
rtl/core/dls_ctrl.sv
rtl/core/dls_out_fifo.sv
rtl/core/dfa_lexer_step.sv
verif/tb_dfa_lexer_step.sv
